// File: rtl/core/qbsd_pkg.sv
// ============================================================================
// qbsd_pkg
// Shared types and constants for the quadratic Bezier subdivider.
// ============================================================================
package qbsd_pkg;

    localparam int CFG_WIDTH = 3;
    localparam logic [CFG_WIDTH-1:0] DEPTH_RESET = 3'd3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

// File: rtl/core/qbsd_midpoint_unit.sv
// ============================================================================
// qbsd_midpoint_unit
// Shared split unit: leg midpoints and curve midpoint of one control triple,
// floor-rounded, for all three axes.
// ============================================================================
module qbsd_midpoint_unit #(
    parameter int W = 32
) (
    input  logic [2:0][W-1:0] i_p0,
    input  logic [2:0][W-1:0] i_p1,
    input  logic [2:0][W-1:0] i_p2,
    output logic [2:0][W-1:0] o_near,
    output logic [2:0][W-1:0] o_far,
    output logic [2:0][W-1:0] o_quarter
);

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [W:0]   sum_near;
        logic [W:0]   sum_far;
        logic [W+1:0] sum_quarter;

        assign sum_near    = {i_p0[a][W-1], i_p0[a]} + {i_p1[a][W-1], i_p1[a]};
        assign sum_far     = {i_p1[a][W-1], i_p1[a]} + {i_p2[a][W-1], i_p2[a]};
        assign sum_quarter = {{2{i_p0[a][W-1]}}, i_p0[a]}
                           + {i_p1[a][W-1], i_p1[a], 1'b0}
                           + {{2{i_p2[a][W-1]}}, i_p2[a]};

        assign o_near[a]    = sum_near[W:1];
        assign o_far[a]     = sum_far[W:1];
        assign o_quarter[a] = sum_quarter[W+1:2];
    end

endmodule

// File: rtl/core/qbsd_stack.sv
// ============================================================================
// qbsd_stack
// Pending right-half triples with their levels, last in first out.
// ============================================================================
module qbsd_stack #(
    parameter int W     = 32,
    parameter int DEPTH = 7,
    parameter int SW    = 3,
    parameter int LW    = 3
) (
    input  logic                 i_clk,
    input  qbsd_pkg::t_stack_ctl i_ctl,
    input  logic [SW-1:0]        i_top,
    input  logic [2:0][W-1:0]    i_p0,
    input  logic [2:0][W-1:0]    i_p1,
    input  logic [2:0][W-1:0]    i_p2,
    input  logic [LW-1:0]        i_level,
    output logic [2:0][W-1:0]    o_p0,
    output logic [2:0][W-1:0]    o_p1,
    output logic [2:0][W-1:0]    o_p2,
    output logic [LW-1:0]        o_level
);

    localparam int EW = 9 * W + LW;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_top_entry;
    logic [SW-1:0] below_idx;

    assign below_idx = i_top - SW'(2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[i_top] <= {i_p0, i_p1, i_p2, i_level};
            r_top_entry  <= {i_p0, i_p1, i_p2, i_level};
        end else if (i_ctl.pop && i_top != SW'(1)) begin
            r_top_entry <= r_mem[below_idx];
        end
    end

    assign {o_p0, o_p1, o_p2, o_level} = r_top_entry;

endmodule

// File: rtl/core/quadratic_bezier_subdivider_unit.sv
// ============================================================================
// quadratic_bezier_subdivider_unit
// De Casteljau subdivision of a 3D quadratic Bezier curve, depth first.
// ============================================================================
// Throughput: one tree node per cycle through the shared midpoint unit, while
// the output does not stall.
// A new request is taken in the cycle after the last pair is registered.
// Reset (synchronous, active low) idles the sequencer, empties the output
// and sets the depth register to 3.
module quadratic_bezier_subdivider_unit #(
    parameter int MAX_DEPTH   = 7,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qbsd_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_middle_x,
    input  logic signed [COORD_WIDTH-1:0] i_middle_y,
    input  logic signed [COORD_WIDTH-1:0] i_middle_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_near_x,
    output logic signed [COORD_WIDTH-1:0] o_near_y,
    output logic signed [COORD_WIDTH-1:0] o_near_z,
    output logic signed [COORD_WIDTH-1:0] o_far_x,
    output logic signed [COORD_WIDTH-1:0] o_far_y,
    output logic signed [COORD_WIDTH-1:0] o_far_z,
    output logic                          o_last_pair
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = qbsd_pkg::CFG_WIDTH;
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef logic [2:0][W-1:0] t_vec3;

    qbsd_pkg::t_state     r_state, n_state;
    qbsd_pkg::t_stack_ctl stk_ctl;

    logic [CW-1:0] r_cfg_depth;
    logic [CW-1:0] depth_clamp;
    logic [LW-1:0] r_depth_eff;
    logic [LW-1:0] r_level;
    logic [SW-1:0] r_top;
    t_vec3         r_p0, r_p1, r_p2;
    t_vec3         near, far, quarter;
    t_vec3         pop_p0, pop_p1, pop_p2;
    logic [LW-1:0] pop_level;
    t_vec3         r_out_near, r_out_far;
    logic          r_out_valid;
    logic          r_out_last;

    logic in_accept;
    logic leaf;
    logic slot_free;
    logic do_emit;

    always_comb begin
        if (r_cfg_depth == '0) begin
            depth_clamp = CW'(1);
        end else if (int'(r_cfg_depth) > MAX_DEPTH) begin
            depth_clamp = CW'(MAX_DEPTH);
        end else begin
            depth_clamp = r_cfg_depth;
        end
    end

    assign in_accept = i_in_valid && (r_state == qbsd_pkg::ST_IDLE);
    assign leaf      = r_level >= r_depth_eff;
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qbsd_pkg::ST_IDLE: begin
                if (in_accept) n_state = qbsd_pkg::ST_RUN;
            end
            qbsd_pkg::ST_RUN: begin
                if (do_emit && r_top == '0) n_state = qbsd_pkg::ST_IDLE;
            end
            default: n_state = qbsd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        stk_ctl = '0;
        do_emit = 1'b0;
        unique case (r_state)
            qbsd_pkg::ST_IDLE: begin
                stk_ctl = '0;
            end
            qbsd_pkg::ST_RUN: begin
                stk_ctl.push = !leaf;
                do_emit      = leaf && slot_free;
                stk_ctl.pop  = leaf && slot_free && (r_top != '0);
            end
            default: stk_ctl = '0;
        endcase
    end

    qbsd_midpoint_unit #(
        .W (W)
    ) u_mid (
        .i_p0      (r_p0),
        .i_p1      (r_p1),
        .i_p2      (r_p2),
        .o_near    (near),
        .o_far     (far),
        .o_quarter (quarter)
    );

    qbsd_stack #(
        .W     (W),
        .DEPTH (MAX_DEPTH),
        .SW    (SW),
        .LW    (LW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_ctl   (stk_ctl),
        .i_top   (r_top),
        .i_p0    (quarter),
        .i_p1    (far),
        .i_p2    (r_p2),
        .i_level (r_level + LW'(1)),
        .o_p0    (pop_p0),
        .o_p1    (pop_p1),
        .o_p2    (pop_p2),
        .o_level (pop_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qbsd_pkg::ST_IDLE;
            r_cfg_depth <= qbsd_pkg::DEPTH_RESET;
            r_depth_eff <= LW'(1);
            r_level     <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg_depth <= i_cfg_data;
            if (in_accept) begin
                r_depth_eff <= depth_clamp[LW-1:0];
                r_level     <= LW'(1);
                r_top       <= '0;
            end else if (stk_ctl.push) begin
                r_level <= r_level + LW'(1);
                r_top   <= r_top + SW'(1);
            end else if (stk_ctl.pop) begin
                r_level <= pop_level;
                r_top   <= r_top - SW'(1);
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p0 <= {i_start_z, i_start_y, i_start_x};
            r_p1 <= {i_middle_z, i_middle_y, i_middle_x};
            r_p2 <= {i_end_z, i_end_y, i_end_x};
        end else if (stk_ctl.push) begin
            r_p1 <= near;
            r_p2 <= quarter;
        end else if (stk_ctl.pop) begin
            r_p0 <= pop_p0;
            r_p1 <= pop_p1;
            r_p2 <= pop_p2;
        end
        if (do_emit) begin
            r_out_near <= near;
            r_out_far  <= far;
            r_out_last <= (r_top == '0);
        end
    end

    assign o_in_stall  = (r_state != qbsd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_near_x    = r_out_near[0];
    assign o_near_y    = r_out_near[1];
    assign o_near_z    = r_out_near[2];
    assign o_far_x     = r_out_far[0];
    assign o_far_y     = r_out_far[1];
    assign o_far_z     = r_out_far[2];
    assign o_last_pair = r_out_last;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_emit && r_top == '0) |=> (r_state == qbsd_pkg::ST_IDLE && o_out_valid && o_last_pair))
        else $error("last pair did not end the request");

    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_ctl.push |-> (int'(r_top) < MAX_DEPTH - 1))
        else $error("stack overflow");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qbsd_pkg::ST_RUN) |-> (r_level <= r_depth_eff && r_level != '0))
        else $error("level out of range");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qbsd_pkg::ST_IDLE) |-> (r_top == '0))
        else $error("stack not empty while idle");

    a_no_emit_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !do_emit)
        else $error("pair overwritten while stalled");

endmodule

// File: tb/quadratic_bezier_subdivider_unit_tb.sv
// ============================================================================
// quadratic_bezier_subdivider_unit_tb
// Self-checking testbench for the quadratic Bezier subdivider. Requests carry
// three 3D control points; a predictor splits the triple depth first, left
// half first, and queues the expected leaf pairs. A checker compares every
// accepted pair field by field. Both sides idle and stall at random, and the
// depth register is swept from zero to seven between drained phases.
// ============================================================================
module quadratic_bezier_subdivider_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEVEL = 7;
    localparam int COORD_W   = 32;
    localparam int NUM_COORD = 9;
    localparam int CFG_W     = qbsd_pkg::CFG_WIDTH;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        t_coord near_x;
        t_coord near_y;
        t_coord near_z;
        t_coord far_x;
        t_coord far_y;
        t_coord far_z;
        logic   last_pair;
    } t_leaf_pair;

    localparam t_coord CMAX = 32'sh7fff_ffff;
    localparam t_coord CMIN = 32'sh8000_0000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_coord           i_start_x, i_start_y, i_start_z;
    t_coord           i_middle_x, i_middle_y, i_middle_z;
    t_coord           i_end_x, i_end_y, i_end_z;
    logic             o_out_valid;
    logic             i_out_stall;
    t_coord           o_near_x, o_near_y, o_near_z;
    t_coord           o_far_x, o_far_y, o_far_z;
    logic             o_last_pair;

    t_leaf_pair       expected_pairs[$];
    logic [CFG_W-1:0] depth_setting;
    int               error_count;
    bit               quiet_mode;

    quadratic_bezier_subdivider_unit #(
        .MAX_DEPTH  (MAX_LEVEL),
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_start_z  (i_start_z),
        .i_middle_x (i_middle_x),
        .i_middle_y (i_middle_y),
        .i_middle_z (i_middle_z),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_end_z    (i_end_z),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_near_x   (o_near_x),
        .o_near_y   (o_near_y),
        .o_near_z   (o_near_z),
        .o_far_x    (o_far_x),
        .o_far_y    (o_far_y),
        .o_far_z    (o_far_z),
        .o_last_pair(o_last_pair)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_coord midpoint(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] sum;
        sum = (COORD_W+1)'(a) + (COORD_W+1)'(b);
        return sum[COORD_W:1];
    endfunction

    function automatic t_coord quarter_point(input t_coord a, input t_coord b,
                                             input t_coord c);
        logic signed [COORD_W+1:0] sum;
        sum = (COORD_W+2)'(a) + (COORD_W+2)'(b) + (COORD_W+2)'(b) + (COORD_W+2)'(c);
        return sum[COORD_W+1:2];
    endfunction

    function automatic void predict_leaf_pairs(input t_coord pts[NUM_COORD]);
        t_coord      cur[NUM_COORD];
        t_coord      right_half[MAX_LEVEL][NUM_COORD];
        int unsigned right_level[MAX_LEVEL];
        int unsigned lvl;
        int unsigned top;
        int unsigned leaf_depth;
        t_coord      q;
        t_leaf_pair  pr;
        leaf_depth = depth_setting;
        if (leaf_depth < 1) leaf_depth = 1;
        if (leaf_depth > MAX_LEVEL) leaf_depth = MAX_LEVEL;
        cur = pts;
        lvl = 1;
        top = 0;
        forever begin
            if (lvl >= leaf_depth) begin
                pr.near_x    = midpoint(cur[0], cur[3]);
                pr.near_y    = midpoint(cur[1], cur[4]);
                pr.near_z    = midpoint(cur[2], cur[5]);
                pr.far_x     = midpoint(cur[3], cur[6]);
                pr.far_y     = midpoint(cur[4], cur[7]);
                pr.far_z     = midpoint(cur[5], cur[8]);
                pr.last_pair = (top == 0);
                expected_pairs.insert(expected_pairs.size(), pr);
                if (top == 0) break;
                top--;
                cur = right_half[top];
                lvl = right_level[top];
            end else begin
                for (int a = 0; a < 3; a++) begin
                    q = quarter_point(cur[a], cur[3+a], cur[6+a]);
                    right_half[top][a]   = q;
                    right_half[top][3+a] = midpoint(cur[3+a], cur[6+a]);
                    right_half[top][6+a] = cur[6+a];
                    cur[3+a]             = midpoint(cur[a], cur[3+a]);
                    cur[6+a]             = q;
                end
                right_level[top] = lvl + 1;
                top++;
                lvl++;
            end
        end
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9)) inside
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            3: return -1;
            [4:5]: return t_coord'($signed($urandom_range(0, 2047)) - 1024);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_request(input t_coord pts[NUM_COORD]);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start_x  = pts[0];
        i_start_y  = pts[1];
        i_start_z  = pts[2];
        i_middle_x = pts[3];
        i_middle_y = pts[4];
        i_middle_z = pts[5];
        i_end_x    = pts[6];
        i_end_y    = pts[7];
        i_end_z    = pts[8];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_leaf_pairs(pts);
    endtask

    task automatic send_random_request();
        t_coord pts[NUM_COORD];
        for (int i = 0; i < NUM_COORD; i++) pts[i] = rand_coord();
        send_request(pts);
    endtask

    task automatic hold_until_drained(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_pairs.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_depth(input logic [CFG_W-1:0] value);
        hold_until_drained(2 * MAX_LEVEL);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        depth_setting = value;
    endtask

    task automatic test_reset_depth();
        t_coord pts[NUM_COORD];
        pts = '{default: '0};
        send_request(pts);
        pts = '{default: CMAX};
        send_request(pts);
        pts = '{default: CMIN};
        send_request(pts);
        pts = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN};
        send_request(pts);
        pts = '{-1, 1, -3, 0, -1, 3, 1, -2, -5};
        send_request(pts);
    endtask

    task automatic test_depth_zero();
        t_coord pts[NUM_COORD];
        write_depth('0);
        pts = '{CMAX, CMIN, -1, CMAX, CMIN, 1, CMIN, CMAX, -1};
        send_request(pts);
        send_random_request();
    endtask

    task automatic test_each_depth();
        for (int d = 1; d <= MAX_LEVEL; d++) begin
            write_depth(CFG_W'(d));
            send_random_request();
        end
    endtask

    task automatic test_back_to_back();
        write_depth(CFG_W'(2));
        quiet_mode = 1'b1;
        repeat (4) send_random_request();
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_phases();
        int phase_depth[8] = '{2, 1, 4, 0, 5, 7, 3, 6};
        int count;
        for (int p = 0; p < 8; p++) begin
            write_depth(CFG_W'(phase_depth[p]));
            quiet_mode = (p % 3 == 1);
            count = (phase_depth[p] >= 6) ? 10 : 24;
            for (int n = 0; n < count; n++) begin
                if ($urandom_range(0, 15) == 0) hold_until_drained(0);
                send_random_request();
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = quiet_mode ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_leaf_pair exp_pr;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_pairs.size() == 0) begin
                $display("%0t: unexpected pair near=(%0d,%0d,%0d) far=(%0d,%0d,%0d) last=%b",
                         $realtime, o_near_x, o_near_y, o_near_z,
                         o_far_x, o_far_y, o_far_z, o_last_pair);
                error_count++;
            end else begin
                exp_pr = expected_pairs.pop_front();
                if (o_near_x !== exp_pr.near_x) begin
                    $display("%0t: near_x expected %0d actual %0d",
                             $realtime, exp_pr.near_x, o_near_x);
                    error_count++;
                end
                if (o_near_y !== exp_pr.near_y) begin
                    $display("%0t: near_y expected %0d actual %0d",
                             $realtime, exp_pr.near_y, o_near_y);
                    error_count++;
                end
                if (o_near_z !== exp_pr.near_z) begin
                    $display("%0t: near_z expected %0d actual %0d",
                             $realtime, exp_pr.near_z, o_near_z);
                    error_count++;
                end
                if (o_far_x !== exp_pr.far_x) begin
                    $display("%0t: far_x expected %0d actual %0d",
                             $realtime, exp_pr.far_x, o_far_x);
                    error_count++;
                end
                if (o_far_y !== exp_pr.far_y) begin
                    $display("%0t: far_y expected %0d actual %0d",
                             $realtime, exp_pr.far_y, o_far_y);
                    error_count++;
                end
                if (o_far_z !== exp_pr.far_z) begin
                    $display("%0t: far_z expected %0d actual %0d",
                             $realtime, exp_pr.far_z, o_far_z);
                    error_count++;
                end
                if (o_last_pair !== exp_pr.last_pair) begin
                    $display("%0t: last_pair expected %b actual %b",
                             $realtime, exp_pr.last_pair, o_last_pair);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("** quadratic_bezier_subdivider_unit: FAILED **");
        $finish;
    end

    initial begin
        error_count   = 0;
        quiet_mode    = 1'b0;
        depth_setting = qbsd_pkg::DEPTH_RESET;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_start_x     = '0;
        i_start_y     = '0;
        i_start_z     = '0;
        i_middle_x    = '0;
        i_middle_y    = '0;
        i_middle_z    = '0;
        i_end_x       = '0;
        i_end_y       = '0;
        i_end_z       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_depth();
        test_depth_zero();
        test_each_depth();
        test_back_to_back();
        test_random_phases();

        hold_until_drained(4 * MAX_LEVEL);
        if (error_count == 0) begin
            $display("** quadratic_bezier_subdivider_unit: PASSED **");
        end else begin
            $display("** quadratic_bezier_subdivider_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: quadratic_bezier_subdivider_unit.f
rtl/core/qbsd_pkg.sv
rtl/core/qbsd_midpoint_unit.sv
rtl/core/qbsd_stack.sv
rtl/core/quadratic_bezier_subdivider_unit.sv
tb/quadratic_bezier_subdivider_unit_tb.sv
